FILE: src/ptma_pkg.sv
// Shared types and codes for the peak table merge/accumulate block.
package ptma_pkg;

  localparam int MZ_W    = 32;
  localparam int PINT_W  = 32;
  localparam int EINT_W  = 40;
  localparam int TOL_W   = 20;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int STAT_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CFGI_W  = 1;

  localparam logic [TOL_W-1:0] MERGE_TOL_RST = 20'd10486;
  localparam logic [TOL_W-1:0] FINE_TOL_RST  = 20'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_REF   = 2'd1,
    MODE_SUB   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_MERGED   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_RD_VALID = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_MERGE_TOL = 1'd0,
    CFG_FINE_TOL  = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_RDOUT
  } state_t;

endpackage

FILE: src/peak_table_merge_accumulate.sv
// Sorted peak table with tolerance merge, insert-by-shift and indexed read.
//
// One command is taken when start is high and busy is low; busy stays high until the
// result word is shown on the out_ ports for one cycle with out_valid (it cannot be
// held off). All work goes through one table RAM with one read and one write port and
// a single compare unit. A clear only sets the count to zero. Adding a peak runs a
// linear search that reads and compares the entries in order from the start; when a
// new entry is inserted, each entry from the end down to its position is read and then
// written one place up. A new command may be given in the cycle the result shows.
// The table holds no reset pass; only entries below the count are ever used.
module peak_table_merge_accumulate #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptma_pkg::MODE_W-1:0]   in_mode,
  input  logic [ptma_pkg::MZ_W-1:0]     in_peak_mz,
  input  logic [ptma_pkg::PINT_W-1:0]   in_peak_intensity,
  input  logic [ptma_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  output logic [ptma_pkg::STAT_W-1:0]   out_status,
  output logic [ptma_pkg::IDX_W-1:0]    out_position,
  output logic [ptma_pkg::MZ_W-1:0]     out_entry_mz,
  output logic [ptma_pkg::EINT_W-1:0]   out_entry_intensity,
  output logic [ptma_pkg::CNT_W-1:0]    out_entry_count,
  input  logic                          cfg_we,
  input  logic [ptma_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [ptma_pkg::TOL_W-1:0]    cfg_wdata
);
  import ptma_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = MZ_W + EINT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]  merge_tol_r, fine_tol_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [MZ_W-1:0]   mz_r;
  logic [PINT_W-1:0] pint_r;
  logic [IDX_W-1:0]  ridx_r;

  logic [DW-1:0]     mem [TABLE_DEPTH];
  logic [DW-1:0]     rd_data_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DW-1:0]     wr_data;
  logic              wr_en;

  logic              ov_nxt;
  logic [STAT_W-1:0] os_nxt;
  logic [IDX_W-1:0]  op_nxt;
  logic [MZ_W-1:0]   om_nxt;
  logic [EINT_W-1:0] oi_nxt;

  logic              ov_r;
  logic [STAT_W-1:0] os_r;
  logic [IDX_W-1:0]  op_r;
  logic [MZ_W-1:0]   om_r;
  logic [EINT_W-1:0] oi_r;

  // shared compare unit
  logic              strict;
  logic [TOL_W-1:0]  tol;
  logic [MZ_W-1:0]   e_mz;
  logic [EINT_W-1:0] e_int;
  logic [MZ_W:0]     e_plus_tol, mz_plus_tol;
  logic              found, hit, at_end, full, rd_in_range, shift_done;
  logic [EINT_W:0]   isum;
  logic [EINT_W-1:0] isat;

  assign strict      = (mode_r == MODE_REF);
  assign tol         = strict ? fine_tol_r : merge_tol_r;
  assign e_mz        = rd_data_r[DW-1 -: MZ_W];
  assign e_int       = rd_data_r[EINT_W-1:0];
  assign e_plus_tol  = (MZ_W+1)'(e_mz) + (MZ_W+1)'(tol);
  assign mz_plus_tol = (MZ_W+1)'(mz_r) + (MZ_W+1)'(tol);
  assign found       = strict ? (e_plus_tol > (MZ_W+1)'(mz_r))
                              : (e_plus_tol >= (MZ_W+1)'(mz_r));
  assign hit         = strict ? ((MZ_W+1)'(e_mz) < mz_plus_tol)
                              : ((MZ_W+1)'(e_mz) <= mz_plus_tol);
  assign isum        = (EINT_W+1)'(e_int) + (EINT_W+1)'(pint_r);
  assign isat        = isum[EINT_W] ? {EINT_W{1'b1}} : isum[EINT_W-1:0];
  assign at_end      = (idx_r == count_r);
  assign full        = (count_r == FULL_CNT);
  assign rd_in_range = (32'(ridx_r) < 32'(count_r));
  assign shift_done  = (k_r == idx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_DISP;
      S_DISP: begin
        case (mode_r)
          MODE_CLEAR: state_nxt = S_IDLE;
          MODE_READ:  state_nxt = rd_in_range ? S_RDOUT : S_IDLE;
          default:    state_nxt = S_SRCH;
        endcase
      end
      S_SRCH: begin
        if (!at_end)   state_nxt = S_CMP;
        else if (full) state_nxt = S_IDLE;
        else           state_nxt = S_SHRD;
      end
      S_CMP: begin
        if (!found)        state_nxt = S_SRCH;
        else if (hit)      state_nxt = S_IDLE;
        else if (full)     state_nxt = S_IDLE;
        else               state_nxt = S_SHRD;
      end
      S_SHRD:  state_nxt = shift_done ? S_IDLE : S_SHWR;
      S_SHWR:  state_nxt = S_SHRD;
      S_RDOUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory ports and result word
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    rd_addr   = AW'(idx_r);
    wr_en     = 1'b0;
    wr_addr   = AW'(idx_r);
    wr_data   = {mz_r, EINT_W'(pint_r)};
    ov_nxt    = 1'b0;
    os_nxt    = ST_EMPTY;
    op_nxt    = '0;
    om_nxt    = '0;
    oi_nxt    = '0;
    case (state_r)
      S_DISP: begin
        idx_nxt = '0;
        rd_addr = AW'(ridx_r);
        case (mode_r)
          MODE_CLEAR: begin
            count_nxt = '0;
            ov_nxt    = 1'b1;
          end
          MODE_READ: begin
            if (!rd_in_range) begin
              ov_nxt = 1'b1;
              op_nxt = ridx_r;
            end
          end
          default: ;
        endcase
      end
      S_SRCH: begin
        k_nxt = count_r;
        if (at_end && full) begin
          ov_nxt = 1'b1;
          os_nxt = ST_DROPPED;
          om_nxt = mz_r;
          oi_nxt = EINT_W'(pint_r);
        end
      end
      S_CMP: begin
        k_nxt = count_r;
        if (!found) begin
          idx_nxt = CW'(idx_r + 1'b1);
        end else if (hit) begin
          wr_en   = 1'b1;
          wr_data = {e_mz, isat};
          ov_nxt  = 1'b1;
          os_nxt  = ST_MERGED;
          op_nxt  = IDX_W'(idx_r);
          om_nxt  = e_mz;
          oi_nxt  = isat;
        end else if (full) begin
          ov_nxt = 1'b1;
          os_nxt = ST_DROPPED;
          om_nxt = mz_r;
          oi_nxt = EINT_W'(pint_r);
        end
      end
      S_SHRD: begin
        rd_addr = AW'(CW'(k_r - 1'b1));
        if (shift_done) begin
          wr_en     = 1'b1;
          count_nxt = CW'(count_r + 1'b1);
          ov_nxt    = 1'b1;
          os_nxt    = ST_INSERTED;
          op_nxt    = IDX_W'(idx_r);
          om_nxt    = mz_r;
          oi_nxt    = EINT_W'(pint_r);
        end
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k_r);
        wr_data = rd_data_r;
        k_nxt   = CW'(k_r - 1'b1);
      end
      S_RDOUT: begin
        ov_nxt = 1'b1;
        os_nxt = ST_RD_VALID;
        op_nxt = ridx_r;
        om_nxt = e_mz;
        oi_nxt = e_int;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      merge_tol_r <= MERGE_TOL_RST;
      fine_tol_r  <= FINE_TOL_RST;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MERGE_TOL: merge_tol_r <= cfg_wdata;
          CFG_FINE_TOL:  fine_tol_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    k_r   <= k_nxt;
    os_r  <= os_nxt;
    op_r  <= op_nxt;
    om_r  <= om_nxt;
    oi_r  <= oi_nxt;
    if (state_r == S_IDLE && start) begin
      mode_r <= in_mode;
      mz_r   <= in_peak_mz;
      pint_r <= in_peak_intensity;
      ridx_r <= in_read_index;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_status          = os_r;
  assign out_position        = op_r;
  assign out_entry_mz        = om_r;
  assign out_entry_intensity = oi_r;
  assign out_entry_count     = CNT_W'(count_r);

endmodule

FILE: src/ptma_chk.sv
// Port-level checks for the peak table block, bound to the top level.
module ptma_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ptma_pkg::STAT_W-1:0] out_status,
  input logic [ptma_pkg::CNT_W-1:0]  out_entry_count
);
  import ptma_pkg::*;

  // a result word only closes a command in flight
  a_res_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result word without a command in flight");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_EMPTY))
    else $error("status code out of range");

  a_touch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MERGED || out_status == ST_INSERTED ||
                   out_status == ST_RD_VALID)) |-> (out_entry_count != '0))
    else $error("table entry touched while count is zero");

endmodule

bind peak_table_merge_accumulate ptma_chk u_ptma_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);
